@@ hw/rtl/cdgc_pkg.sv @@
// Shared types, constants and helper functions for the command datagram checker.
package cdgc_pkg;

  localparam int HDR_LEN = 20;
  localparam int LED_LEN = 4;

  localparam logic [31:0] CMD_MAGIC = 32'h5344_4D43;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

  localparam logic [15:0] HDR_VERSION = 16'd1;
  localparam logic [15:0] HDR_CMD_LED = 16'd1;
  localparam logic [15:0] HDR_CMD_LCD = 16'd2;

  localparam logic [7:0] LCD_LINE1 = 8'd1;
  localparam logic [7:0] LCD_LINE2 = 8'd2;
  localparam logic [7:0] LCD_LINE3 = 8'd3;

  localparam logic [6:0] CURSOR_LINE0 = 7'h00;
  localparam logic [6:0] CURSOR_LINE1 = 7'h40;
  localparam logic [6:0] CURSOR_LINE2 = 7'h14;
  localparam logic [6:0] CURSOR_LINE3 = 7'h54;

  typedef enum logic [3:0] {
    ST_LED_OK     = 4'd0,
    ST_LCD_OK     = 4'd1,
    ST_SHORT      = 4'd2,
    ST_MAGIC      = 4'd3,
    ST_VERSION    = 4'd4,
    ST_LENGTH     = 4'd5,
    ST_TOO_LONG   = 4'd6,
    ST_CRC        = 4'd7,
    ST_LCD_ABSENT = 4'd8,
    ST_IGNORED    = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_LED  = 2'd1,
    ACT_LCD  = 2'd2
  } action_t;

  // Judged datagram, waiting for or in the drain.
  typedef struct packed {
    status_t     status;
    action_t     command;
    logic [31:0] sequence_res;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  lcd_line;
    logic [6:0]  lcd_position;
    logic        bank;
  } job_t;

  // One result transaction.
  typedef struct packed {
    status_t     status;
    action_t     command;
    logic [31:0] sequence_res;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  lcd_line;
    logic [6:0]  lcd_position;
    logic [7:0]  text_byte;
    logic        is_text;
    logic        last;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [6:0] cursor_of(input logic [7:0] line);
    logic [6:0] pos;
    case (line)
      LCD_LINE1: pos = CURSOR_LINE1;
      LCD_LINE2: pos = CURSOR_LINE2;
      LCD_LINE3: pos = CURSOR_LINE3;
      default:   pos = CURSOR_LINE0;
    endcase
    return pos;
  endfunction

endpackage

@@ hw/rtl/cdgc_parser.sv @@
// Header capture, running CRC, payload store writes and end-of-datagram judgment.
module cdgc_parser import cdgc_pkg::*; #(
  parameter int MAX_DATAGRAM = 512,
  parameter int MAX_PAYLOAD  = 256,
  parameter int TEXT_LEN     = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take,
  input  logic [7:0]                        data_byte,
  input  logic                              end_flag,
  input  logic                              lcd_available,
  output logic                              wr_en,
  output logic [$clog2(TEXT_LEN+1):0]       wr_addr,
  output logic [7:0]                        wr_data,
  output logic                              job_valid,
  output job_t                              job
);

  localparam int STORE_LEN = TEXT_LEN + 1;
  localparam int IDX_W     = $clog2(STORE_LEN);
  localparam int CNT_W     = $clog2(MAX_DATAGRAM + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_upd, pidx;
  logic [31:0]      crc_r, crc_nxt, crc_upd;
  logic [31:0]      magic_r, magic_nxt, magic_upd;
  logic [15:0]      version_r, version_nxt, version_upd;
  logic [15:0]      command_r, command_nxt, command_upd;
  logic [31:0]      seq_r, seq_nxt, seq_upd;
  logic [15:0]      length_r, length_nxt, length_upd;
  logic [31:0]      rcrc_r, rcrc_nxt, rcrc_upd;
  logic [7:0]       b0_r, b1_r, b2_r, b0_upd, b1_upd, b2_upd;
  logic             bank_r, bank_nxt;
  logic             in_range, is_crc_field, in_store;
  logic [16:0]      exp_len;
  status_t          status;

  always_comb begin
    cnt_upd      = cnt_r;
    crc_upd      = crc_r;
    magic_upd    = magic_r;
    version_upd  = version_r;
    command_upd  = command_r;
    seq_upd      = seq_r;
    length_upd   = length_r;
    rcrc_upd     = rcrc_r;
    b0_upd       = b0_r;
    b1_upd       = b1_r;
    b2_upd       = b2_r;
    in_range     = cnt_r < CNT_W'(MAX_DATAGRAM);
    pidx         = cnt_r - CNT_W'(HDR_LEN);
    is_crc_field = (cnt_r >= CNT_W'(16)) && (cnt_r < CNT_W'(HDR_LEN));
    in_store     = in_range && (cnt_r >= CNT_W'(HDR_LEN)) && (pidx < CNT_W'(STORE_LEN));
    if (in_range) begin
      cnt_upd = cnt_r + 1'b1;
      crc_upd = crc_byte(crc_r, is_crc_field ? 8'h00 : data_byte);
      if (cnt_r < CNT_W'(4)) begin
        magic_upd[8*cnt_r[1:0] +: 8] = data_byte;
      end else if (cnt_r < CNT_W'(6)) begin
        version_upd[8*cnt_r[0] +: 8] = data_byte;
      end else if (cnt_r < CNT_W'(8)) begin
        command_upd[8*cnt_r[0] +: 8] = data_byte;
      end else if (cnt_r < CNT_W'(12)) begin
        seq_upd[8*cnt_r[1:0] +: 8] = data_byte;
      end else if (cnt_r < CNT_W'(14)) begin
        length_upd[8*cnt_r[0] +: 8] = data_byte;
      end else if (is_crc_field) begin
        rcrc_upd[8*cnt_r[1:0] +: 8] = data_byte;
      end
    end
    if (in_store && pidx == CNT_W'(0)) b0_upd = data_byte;
    if (in_store && pidx == CNT_W'(1)) b1_upd = data_byte;
    if (in_store && pidx == CNT_W'(2)) b2_upd = data_byte;
  end

  assign wr_en   = take && in_store;
  assign wr_addr = {bank_r, pidx[IDX_W-1:0]};
  assign wr_data = data_byte;

  // Judge on the values that include the final byte.
  always_comb begin
    exp_len = 17'(HDR_LEN) + {1'b0, length_upd};
    if (cnt_upd < CNT_W'(HDR_LEN))                          status = ST_SHORT;
    else if (magic_upd != CMD_MAGIC)                        status = ST_MAGIC;
    else if (version_upd != HDR_VERSION)                    status = ST_VERSION;
    else if (17'(cnt_upd) != exp_len)                       status = ST_LENGTH;
    else if (length_upd > 16'(MAX_PAYLOAD))                 status = ST_TOO_LONG;
    else if (~crc_upd != rcrc_upd)                          status = ST_CRC;
    else if (command_upd == HDR_CMD_LED && length_upd == 16'(LED_LEN)) status = ST_LED_OK;
    else if (command_upd == HDR_CMD_LCD && length_upd == 16'(STORE_LEN))
      status = lcd_available ? ST_LCD_OK : ST_LCD_ABSENT;
    else                                                    status = ST_IGNORED;
  end

  always_comb begin
    job              = '0;
    job.status       = status;
    job.command      = ACT_NONE;
    job.sequence_res = seq_upd;
    job.bank         = bank_r;
    if (status == ST_LED_OK) begin
      job.command = ACT_LED;
      job.red     = b0_upd;
      job.green   = b1_upd;
      job.blue    = b2_upd;
    end else if (status == ST_LCD_OK) begin
      job.command      = ACT_LCD;
      job.lcd_line     = b0_upd;
      job.lcd_position = cursor_of(b0_upd);
    end
  end

  assign job_valid = take && end_flag;

  always_comb begin
    cnt_nxt     = cnt_r;
    crc_nxt     = crc_r;
    magic_nxt   = magic_r;
    version_nxt = version_r;
    command_nxt = command_r;
    seq_nxt     = seq_r;
    length_nxt  = length_r;
    rcrc_nxt    = rcrc_r;
    bank_nxt    = bank_r;
    if (take && end_flag) begin
      cnt_nxt     = '0;
      crc_nxt     = CRC_INIT;
      magic_nxt   = '0;
      version_nxt = '0;
      command_nxt = '0;
      seq_nxt     = '0;
      length_nxt  = '0;
      rcrc_nxt    = '0;
      bank_nxt    = ~bank_r;
    end else if (take) begin
      cnt_nxt     = cnt_upd;
      crc_nxt     = crc_upd;
      magic_nxt   = magic_upd;
      version_nxt = version_upd;
      command_nxt = command_upd;
      seq_nxt     = seq_upd;
      length_nxt  = length_upd;
      rcrc_nxt    = rcrc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      crc_r     <= CRC_INIT;
      magic_r   <= '0;
      version_r <= '0;
      command_r <= '0;
      seq_r     <= '0;
      length_r  <= '0;
      rcrc_r    <= '0;
      bank_r    <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      crc_r     <= crc_nxt;
      magic_r   <= magic_nxt;
      version_r <= version_nxt;
      command_r <= command_nxt;
      seq_r     <= seq_nxt;
      length_r  <= length_nxt;
      rcrc_r    <= rcrc_nxt;
      bank_r    <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b0_r <= b0_upd;
      b1_r <= b1_upd;
      b2_r <= b2_upd;
    end
  end

endmodule

@@ hw/rtl/cdgc_drain.sv @@
// Payload memory, pending and active job slots, and the result output register.
module cdgc_drain import cdgc_pkg::*; #(
  parameter int TEXT_LEN = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [$clog2(TEXT_LEN+1):0] wr_addr,
  input  logic [7:0]                  wr_data,
  input  logic                        job_valid,
  input  job_t                        job,
  output logic                        pend_free,
  input  logic                        out_ready,
  output logic                        out_valid,
  output result_t                     res
);

  localparam int STORE_LEN = TEXT_LEN + 1;
  localparam int IDX_W     = $clog2(STORE_LEN);
  localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

  logic [7:0]       mem [MEM_DEPTH];
  logic [7:0]       rd_data_r;
  logic [IDX_W:0]   rd_addr;

  logic             pend_valid_r, pend_valid_nxt;
  job_t             pend_job_r, pend_job_nxt;
  logic             act_valid_r, act_valid_nxt;
  job_t             act_job_r, act_job_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r, res_nxt;
  logic             load, act_last, act_finish, pend_take;

  assign load       = act_valid_r && (!out_valid_r || out_ready);
  assign act_last   = (act_job_r.command != ACT_LCD) || (k_r == IDX_W'(TEXT_LEN));
  assign act_finish = load && act_last;
  assign pend_take  = pend_valid_r && (!act_valid_r || act_finish);
  assign pend_free  = !pend_valid_r || pend_take;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_job_nxt   = pend_job_r;
    if (pend_take) pend_valid_nxt = 1'b0;
    if (job_valid) begin
      pend_valid_nxt = 1'b1;
      pend_job_nxt   = job;
    end
  end

  always_comb begin
    act_valid_nxt = act_valid_r;
    act_job_nxt   = act_job_r;
    k_nxt         = k_r;
    if (pend_take) begin
      act_valid_nxt = 1'b1;
      act_job_nxt   = pend_job_r;
      k_nxt         = '0;
    end else if (act_finish) begin
      act_valid_nxt = 1'b0;
    end else if (load) begin
      k_nxt = k_r + 1'b1;
    end
  end

  // Address the entry the next cycle's result needs, so read data lines up.
  assign rd_addr = {act_job_nxt.bank, k_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (load) begin
      out_valid_nxt        = 1'b1;
      res_nxt.status       = act_job_r.status;
      res_nxt.command      = act_job_r.command;
      res_nxt.sequence_res = act_job_r.sequence_res;
      res_nxt.red          = act_job_r.red;
      res_nxt.green        = act_job_r.green;
      res_nxt.blue         = act_job_r.blue;
      res_nxt.lcd_line     = act_job_r.lcd_line;
      res_nxt.lcd_position = act_job_r.lcd_position;
      res_nxt.is_text      = (k_r != '0);
      res_nxt.text_byte    = (k_r != '0) ? rd_data_r : 8'h00;
      res_nxt.last         = act_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      act_valid_r  <= 1'b0;
      k_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      act_valid_r  <= act_valid_nxt;
      k_r          <= k_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_job_r <= pend_job_nxt;
    act_job_r  <= act_job_nxt;
    res_r      <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

@@ hw/rtl/command_datagram_checker_core.sv @@
// Top level of the command datagram checker: byte intake, judgment and result drain.
// Throughput: one datagram byte per cycle in while in_ready is high, one result
//   transaction per cycle out while out_ready is high. A datagram's first result passes the
//   pending and active slots and output register; an LCD datagram drains 1+TEXT_LEN results.
// in_ready drops only while a judged datagram waits behind one whose results still drain;
//   the two-bank payload memory lets the next datagram fill while the previous one drains.
// Reset (rst_n, synchronous, active low) clears counters, CRC, header words and valid bits;
//   the payload memory is not cleared and needs no clearing pass.
module command_datagram_checker_core import cdgc_pkg::*; #(
  parameter int MAX_DATAGRAM = 512,
  parameter int MAX_PAYLOAD  = 256,
  parameter int TEXT_LEN     = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_datagram,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [1:0]  out_command,
  output logic [31:0] out_sequence_res,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_lcd_line,
  output logic [6:0]  out_lcd_position,
  output logic [7:0]  out_text_byte,
  output logic        out_is_text,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  localparam int IDX_W = $clog2(TEXT_LEN + 1);

  logic             lcd_available_r, lcd_available_nxt;
  logic             take;
  logic             wr_en;
  logic [IDX_W:0]   wr_addr;
  logic [7:0]       wr_data;
  logic             job_valid;
  job_t             job;
  logic             pend_free;
  result_t          res;

  // Hold the display-link flag; write it only while the block is idle.
  assign lcd_available_nxt = cfg_wr_en ? cfg_wr_data : lcd_available_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_available_r <= 1'b0;
    end else begin
      lcd_available_r <= lcd_available_nxt;
    end
  end

  // Accept a byte whenever the pending job slot can take a judgment this cycle.
  assign in_ready = pend_free;
  assign take     = in_valid && in_ready;

  // Parse header fields, advance the CRC and write the payload bank.
  cdgc_parser #(
    .MAX_DATAGRAM (MAX_DATAGRAM),
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .TEXT_LEN     (TEXT_LEN)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .data_byte     (in_data_byte),
    .end_flag      (in_end_of_datagram),
    .lcd_available (lcd_available_r),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .job_valid     (job_valid),
    .job           (job)
  );

  // Queue judged datagrams and drain their result transactions.
  cdgc_drain #(
    .TEXT_LEN (TEXT_LEN)
  ) u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .job_valid (job_valid),
    .job       (job),
    .pend_free (pend_free),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_status       = res.status;
  assign out_command      = res.command;
  assign out_sequence_res = res.sequence_res;
  assign out_red          = res.red;
  assign out_green        = res.green;
  assign out_blue         = res.blue;
  assign out_lcd_line     = res.lcd_line;
  assign out_lcd_position = res.lcd_position;
  assign out_text_byte    = res.text_byte;
  assign out_is_text      = res.is_text;
  assign out_last         = res.last;

  // A text character only travels with an accepted LCD line.
  a_text_is_lcd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_text |-> out_status == ST_LCD_OK && out_command == ACT_LCD)
    else $error("text result without LCD status");

  // Any refusal carries no action.
  a_refusal_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_LED_OK && out_status != ST_LCD_OK |-> out_command == ACT_NONE)
    else $error("refused datagram reports an action");

  // The LCD line header is always followed by its text.
  a_lcd_head_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_text && out_status == ST_LCD_OK |-> !out_last)
    else $error("LCD line header marked last");

endmodule

@@ tb/cdgc_tb_pkg.sv @@
// CRC helper shared by the datagram generator and the result checker.
package cdgc_tb_pkg;
  import cdgc_pkg::*;

  // Advance a reflected CRC-32 by one byte, one data bit at a time, LSB first.
  function automatic logic [31:0] crc32_next(input logic [31:0] acc, input logic [7:0] d);
    logic [31:0] c;
    logic        fb;
    c = acc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ d[k];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

endpackage

@@ tb/cdgc_result_checker.sv @@
// Scoreboard for the command datagram checker: predicts result transactions and compares them.
module cdgc_result_checker import cdgc_pkg::*, cdgc_tb_pkg::*; #(
  parameter int MAX_DATAGRAM = 512,
  parameter int MAX_PAYLOAD  = 256,
  parameter int TEXT_LEN     = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_datagram,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_status,
  input  logic [1:0]  out_command,
  input  logic [31:0] out_sequence_res,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_lcd_line,
  input  logic [6:0]  out_lcd_position,
  input  logic [7:0]  out_text_byte,
  input  logic        out_is_text,
  input  logic        out_last,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output int          err_count,
  output int          owed_count,
  output int          checked_count
);

  localparam int KEEP_LEN = 1 + TEXT_LEN;

  int          rx_count;
  logic [31:0] crc_acc;
  logic [31:0] hdr_magic;
  logic [15:0] hdr_version;
  logic [15:0] hdr_cmd;
  logic [31:0] hdr_seq;
  logic [15:0] hdr_len;
  logic [31:0] hdr_crc;
  logic [7:0]  kept [KEEP_LEN];
  logic        lcd_present;
  result_t     owed [$];

  function automatic logic [6:0] line_cursor(input logic [7:0] line);
    if (line == LCD_LINE1) return CURSOR_LINE1;
    if (line == LCD_LINE2) return CURSOR_LINE2;
    if (line == LCD_LINE3) return CURSOR_LINE3;
    return CURSOR_LINE0;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf({"status=%0d cmd=%0d seq=%08h rgb=%02h/%02h/%02h line=%0d pos=%02h ",
                      "text=%02h is_text=%b last=%b"},
                     r.status, r.command, r.sequence_res, r.red, r.green, r.blue,
                     r.lcd_line, r.lcd_position, r.text_byte, r.is_text, r.last);
  endfunction

  task automatic restart_datagram();
    rx_count    = 0;
    crc_acc     = CRC_INIT;
    hdr_magic   = '0;
    hdr_version = '0;
    hdr_cmd     = '0;
    hdr_seq     = '0;
    hdr_len     = '0;
    hdr_crc     = '0;
  endtask

  // Judge the finished datagram and queue the result transactions it owes.
  task automatic judge_datagram();
    result_t r;
    r = '0;
    r.sequence_res = hdr_seq;
    r.last = 1'b1;
    if (rx_count < HDR_LEN) r.status = ST_SHORT;
    else if (hdr_magic != CMD_MAGIC) r.status = ST_MAGIC;
    else if (hdr_version != HDR_VERSION) r.status = ST_VERSION;
    else if (rx_count != HDR_LEN + int'(hdr_len)) r.status = ST_LENGTH;
    else if (int'(hdr_len) > MAX_PAYLOAD) r.status = ST_TOO_LONG;
    else if (~crc_acc != hdr_crc) r.status = ST_CRC;
    else if (hdr_cmd == HDR_CMD_LED && hdr_len == LED_LEN) begin
      r.status  = ST_LED_OK;
      r.command = ACT_LED;
      r.red     = kept[0];
      r.green   = kept[1];
      r.blue    = kept[2];
    end else if (hdr_cmd == HDR_CMD_LCD && hdr_len == KEEP_LEN) begin
      if (!lcd_present) begin
        r.status = ST_LCD_ABSENT;
      end else begin
        r.status       = ST_LCD_OK;
        r.command      = ACT_LCD;
        r.lcd_line     = kept[0];
        r.lcd_position = line_cursor(kept[0]);
        r.last         = 1'b0;
        owed.push_back(r);
        r.is_text = 1'b1;
        for (int k = 1; k < KEEP_LEN - 1; k++) begin
          r.text_byte = kept[k];
          owed.push_back(r);
        end
        r.text_byte = kept[KEEP_LEN - 1];
        r.last      = 1'b1;
      end
    end else begin
      r.status = ST_IGNORED;
    end
    owed.push_back(r);
  endtask

  task automatic take_byte(input logic [7:0] d, input logic eod);
    if (rx_count < MAX_DATAGRAM) begin
      if (rx_count < 4) hdr_magic[8*rx_count +: 8] = d;
      else if (rx_count < 6) hdr_version[8*(rx_count-4) +: 8] = d;
      else if (rx_count < 8) hdr_cmd[8*(rx_count-6) +: 8] = d;
      else if (rx_count < 12) hdr_seq[8*(rx_count-8) +: 8] = d;
      else if (rx_count < 14) hdr_len[8*(rx_count-12) +: 8] = d;
      else if (rx_count >= 16 && rx_count < HDR_LEN) hdr_crc[8*(rx_count-16) +: 8] = d;
      else if (rx_count >= HDR_LEN && rx_count < HDR_LEN + KEEP_LEN)
        kept[rx_count-HDR_LEN] = d;
      // the CRC field itself enters the CRC as zeros
      crc_acc = crc32_next(crc_acc, (rx_count >= 16 && rx_count < HDR_LEN) ? 8'h00 : d);
      rx_count++;
    end
    if (eod) begin
      judge_datagram();
      restart_datagram();
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (owed.size() == 0) begin
      err_count++;
      if (err_count <= 10) $display("%0t: unexpected result transaction: %s", $time, show(got));
    end else begin
      want = owed.pop_front();
      checked_count++;
      if (got !== want) begin
        err_count++;
        if (err_count <= 10) begin
          $display("%0t: result transaction mismatch", $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_datagram();
      lcd_present = 1'b0;
    end else begin
      if (cfg_wr_en) lcd_present = cfg_wr_data;
      // retire the output first so a result can never match an expectation queued this edge
      if (out_valid && out_ready)
        check_result({out_status, out_command, out_sequence_res, out_red, out_green, out_blue,
                      out_lcd_line, out_lcd_position, out_text_byte, out_is_text, out_last});
      if (in_valid && in_ready) take_byte(in_data_byte, in_end_of_datagram);
    end
    owed_count = owed.size();
  end

endmodule

@@ tb/tb.sv @@
// Testbench top: datagram stimulus, result backpressure and verdict for the checker core.
module tb import cdgc_pkg::*, cdgc_tb_pkg::*;;

  localparam int MAX_DATAGRAM = 512;
  localparam int MAX_PAYLOAD  = 256;
  localparam int TEXT_LEN     = 20;
  localparam int LCD_LEN      = 1 + TEXT_LEN;
  // Far above the slowest legal run: every byte and every result behind the longest stall.
  localparam int LIMIT_CYCLES = 10_000_000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_datagram = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [3:0]  out_status;
  logic [1:0]  out_command;
  logic [31:0] out_sequence_res;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_lcd_line;
  logic [6:0]  out_lcd_position;
  logic [7:0]  out_text_byte;
  logic        out_is_text;
  logic        out_last;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;

  int err_count;
  int owed_count;
  int checked_count;

  // Datagram under construction and its payload.
  logic [7:0] dgram [$];
  logic [7:0] body [$];

  logic quiet = 1'b0;   // no new idle gaps started on either side while set
  int   sink_left = 0;
  int   bytes_sent = 0;
  int   dgrams_sent = 0;
  int   link_writes = 0;

  command_datagram_checker_core #(
    .MAX_DATAGRAM(MAX_DATAGRAM),
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .TEXT_LEN    (TEXT_LEN)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_datagram(in_end_of_datagram),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_command       (out_command),
    .out_sequence_res  (out_sequence_res),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_lcd_line      (out_lcd_line),
    .out_lcd_position  (out_lcd_position),
    .out_text_byte     (out_text_byte),
    .out_is_text       (out_is_text),
    .out_last          (out_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  cdgc_result_checker #(
    .MAX_DATAGRAM(MAX_DATAGRAM),
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .TEXT_LEN    (TEXT_LEN)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_datagram(in_end_of_datagram),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_command       (out_command),
    .out_sequence_res  (out_sequence_res),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_lcd_line      (out_lcd_line),
    .out_lcd_position  (out_lcd_position),
    .out_text_byte     (out_text_byte),
    .out_is_text       (out_is_text),
    .out_last          (out_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .err_count         (err_count),
    .owed_count        (owed_count),
    .checked_count     (checked_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Backpressure the result channel: alternate runs of ready with stalls of random length.
  // A quiet stretch starts no new stalls, so results stream back to back once ready is high.
  always @(negedge clk) begin
    if (sink_left > 0) begin
      sink_left--;
    end else if (out_ready && !quiet) begin
      out_ready = 1'b0;
      sink_left = gap_len();
    end else begin
      out_ready = 1'b1;
      sink_left = $urandom_range(0, 12);
    end
  end

  task automatic rand_body(input int n);
    body.delete();
    repeat (n) body.push_back(8'($urandom));
  endtask

  // Assemble a datagram around the current payload: little-endian header, random reserved
  // bytes, CRC over the first MAX_DATAGRAM bytes with the CRC field taken as zero.
  task automatic frame(input logic [31:0] magic, input logic [15:0] ver, input logic [15:0] cmd,
                       input logic [31:0] seq, input logic [15:0] len_field, input logic bad_crc);
    logic [31:0] acc;
    dgram.delete();
    for (int k = 0; k < 4; k++) dgram.push_back(magic[8*k +: 8]);
    for (int k = 0; k < 2; k++) dgram.push_back(ver[8*k +: 8]);
    for (int k = 0; k < 2; k++) dgram.push_back(cmd[8*k +: 8]);
    for (int k = 0; k < 4; k++) dgram.push_back(seq[8*k +: 8]);
    for (int k = 0; k < 2; k++) dgram.push_back(len_field[8*k +: 8]);
    repeat (2) dgram.push_back(8'($urandom));
    repeat (4) dgram.push_back(8'h00);
    foreach (body[k]) dgram.push_back(body[k]);
    acc = CRC_INIT;
    for (int k = 0; k < dgram.size() && k < MAX_DATAGRAM; k++) acc = crc32_next(acc, dgram[k]);
    acc = ~acc;
    // flip one CRC bit to force a checksum failure
    if (bad_crc) acc = acc ^ (32'h1 << $urandom_range(0, 31));
    for (int k = 0; k < 4; k++) dgram[16+k] = acc[8*k +: 8];
  endtask

  // Send the datagram byte by byte; valid holds until each transaction is accepted.
  task automatic send_dgram();
    int gap;
    for (int k = 0; k < dgram.size(); k++) begin
      gap = quiet ? 0 : gap_len();
      @(negedge clk);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid           = 1'b1;
      in_data_byte       = dgram[k];
      in_end_of_datagram = (k == dgram.size() - 1);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      bytes_sent++;
    end
    dgrams_sent++;
  endtask

  task automatic send_good(input logic [15:0] cmd, input logic [31:0] seq,
                           input logic [15:0] len_field);
    frame(CMD_MAGIC, HDR_VERSION, cmd, seq, len_field, 1'b0);
    send_dgram();
  endtask

  // Drop valid and hold until every owed result has come back, then let the pipe settle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (owed_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the display-link register, only with the block idle.
  task automatic set_lcd_link(input logic on);
    wait_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = on;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    link_writes++;
  endtask

  // Mostly well-formed LED and LCD datagrams with random content; the rest is corrupted
  // headers, cut or padded datagrams, stray commands and plain noise.
  task automatic random_phase(input int byte_goal, input int dgram_goal);
    int b0;
    int d0;
    int p;
    b0 = bytes_sent;
    d0 = dgrams_sent;
    while (bytes_sent - b0 < byte_goal || dgrams_sent - d0 < dgram_goal) begin
      quiet = ($urandom_range(0, 4) == 0);
      p = $urandom_range(0, 99);
      if (p < 35) begin
        rand_body(LED_LEN);
        send_good(HDR_CMD_LED, $urandom, 16'(LED_LEN));
      end else if (p < 65) begin
        rand_body(LCD_LEN);
        if ($urandom_range(0, 3) != 0) body[0] = 8'($urandom_range(0, 3));
        send_good(HDR_CMD_LCD, $urandom, 16'(LCD_LEN));
      end else if (p < 77) begin
        // flip one header bit
        rand_body(LED_LEN);
        frame(CMD_MAGIC, HDR_VERSION, HDR_CMD_LED, $urandom, 16'(LED_LEN), 1'b0);
        dgram[$urandom_range(0, HDR_LEN - 1)] ^= 8'h01 << $urandom_range(0, 7);
        send_dgram();
      end else if (p < 85) begin
        // cut short or pad past the declared length
        rand_body(LCD_LEN);
        frame(CMD_MAGIC, HDR_VERSION, HDR_CMD_LCD, $urandom, 16'(LCD_LEN), 1'b0);
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 30)) void'(dgram.pop_back());
        else repeat ($urandom_range(1, 3)) dgram.push_back(8'($urandom));
        send_dgram();
      end else if (p < 92) begin
        // any command with any small payload, checksum intact
        rand_body($urandom_range(0, 24));
        frame(CMD_MAGIC, HDR_VERSION, 16'($urandom_range(0, 3)), $urandom, 16'(body.size()),
              1'b0);
        send_dgram();
      end else begin
        dgram.delete();
        repeat ($urandom_range(1, 40)) dgram.push_back(8'($urandom));
        if ($urandom_range(0, 1) && dgram.size() >= 4)
          for (int k = 0; k < 4; k++) dgram[k] = CMD_MAGIC[8*k +: 8];
        send_dgram();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    logic [7:0] lines [5];
    lines = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd255};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every verdict but LCD OK, with the display link absent.
    set_lcd_link(1'b0);

    // runt of one byte, then a header one byte short
    dgram.delete();
    dgram.push_back(8'hFF);
    send_dgram();
    rand_body(LED_LEN);
    frame(CMD_MAGIC, HDR_VERSION, HDR_CMD_LED, 32'h1234_5678, 16'(LED_LEN), 1'b0);
    repeat (LED_LEN + 1) void'(dgram.pop_back());
    send_dgram();

    // LED colors at the extremes
    rand_body(LED_LEN);
    body[0] = 8'hFF;
    body[1] = 8'h00;
    body[2] = 8'h80;
    send_good(HDR_CMD_LED, 32'hFFFF_FFFF, 16'(LED_LEN));

    // header faults in check order
    frame(CMD_MAGIC ^ 32'h8000_0000, HDR_VERSION, HDR_CMD_LED, $urandom, 16'(LED_LEN), 1'b0);
    send_dgram();
    frame(CMD_MAGIC, 16'h0000, HDR_CMD_LED, $urandom, 16'(LED_LEN), 1'b0);
    send_dgram();
    frame(CMD_MAGIC, HDR_VERSION, HDR_CMD_LED, $urandom, 16'(LED_LEN + 1), 1'b0);
    send_dgram();
    frame(CMD_MAGIC, HDR_VERSION, HDR_CMD_LED, $urandom, 16'(LED_LEN), 1'b1);
    send_dgram();

    // LCD refused while the link is absent
    rand_body(LCD_LEN);
    send_good(HDR_CMD_LCD, $urandom, 16'(LCD_LEN));

    // unknown command is ignored
    rand_body(LED_LEN);
    send_good(16'h0000, $urandom, 16'(LED_LEN));

    // overlong datagram: bytes past MAX_DATAGRAM drop, so the capped count matches a
    // length field that is itself over MAX_PAYLOAD
    rand_body(MAX_DATAGRAM - HDR_LEN + 1);
    send_good(HDR_CMD_LED, $urandom, 16'(MAX_DATAGRAM - HDR_LEN));

    // Directed: LCD lines with the link present, every cursor row and one other.
    set_lcd_link(1'b1);
    foreach (lines[k]) begin
      rand_body(LCD_LEN);
      body[0] = lines[k];
      body[1] = 8'h00;
      body[LCD_LEN - 1] = 8'hFF;
      send_good(HDR_CMD_LCD, $urandom, 16'(LCD_LEN));
    end

    // A short random mix with the link present.
    random_phase(40, 2);

    wait_drained();
    repeat (10) @(negedge clk);

    $display("Sent %0d datagrams (%0d bytes) over %0d display-link settings;",
             dgrams_sent, bytes_sent, link_writes);
    $display("checked %0d result transactions, %0d failures.", checked_count, err_count);
    if (err_count == 0 && owed_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(LIMIT_CYCLES * 10);
    $display("Timeout: %0d result transactions still owed", owed_count);
    $display("TB_ERROR");
    $finish;
  end

endmodule
